// File: rtl/encoder_position_window_velocity_defines.svh
// assertion macros used by the rtl
`ifndef ENCODER_POSITION_WINDOW_VELOCITY_DEFINES_SVH
`define ENCODER_POSITION_WINDOW_VELOCITY_DEFINES_SVH

// same-cycle implication, checked only out of reset
`define EPVW_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked only out of reset
`define EPVW_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/epvw_pkg.sv
package epvw_pkg;

  // depth of the position history window
  localparam int WINDOW    = 16;
  // cells needed to reach the oldest total the window compares against
  localparam int CHAIN_LEN = WINDOW - 1;
  localparam int SLOT_W    = $clog2(WINDOW);

  localparam int CNT_W  = 16;
  localparam int TOT_W  = 32;
  localparam int GAIN_W = 32;
  localparam int POS_W  = 48;
  localparam int VEL_W  = 32;
  localparam int PROD_W = 64;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_POS_GAIN    = 2'd0,
    CFG_TICK_GAIN   = 2'd1,
    CFG_WINDOW_GAIN = 2'd2
  } cfg_reg_t;

  typedef logic [TOT_W-1:0] total_t;

endpackage

// File: rtl/epvw_cell.sv
module epvw_cell (
  input  logic                 clk,
  input  logic                 shift_en,
  input  epvw_pkg::total_t     data_in,
  output epvw_pkg::total_t     data_out
);

  epvw_pkg::total_t data_r;

  // one history slot, moves one place down the chain per beat
  always_ff @(posedge clk) begin
    if (shift_en) begin
      data_r <= data_in;
    end
  end

  assign data_out = data_r;

endmodule

// File: rtl/encoder_position_window_velocity.sv
// an accepted beat passes the stage 1, stage 2 and output registers before its result beat is valid
// throughput: one beat per cycle while out_stall does not hold the pipe, set by the three-stage multiply pipeline
// each stage holds its beat while the stage after it is full and stalled
// reset (rst_n low, synchronous): gains, last reading, total, slot and fill flag cleared
// the history chain is not cleared; its entries are only used once fully written
`include "encoder_position_window_velocity_defines.svh"

module encoder_position_window_velocity (
  input  logic                            clk,
  input  logic                            rst_n,
  // configuration write port
  input  logic                            cfg_wr_en,
  input  logic [1:0]                      cfg_index,
  input  logic [epvw_pkg::GAIN_W-1:0]     cfg_wdata,
  // counter reading beats
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [epvw_pkg::CNT_W-1:0]      in_counter_value,
  // result beats
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic signed [epvw_pkg::TOT_W-1:0] out_count_total,
  output logic signed [epvw_pkg::POS_W-1:0] out_position,
  output logic signed [epvw_pkg::VEL_W-1:0] out_velocity,
  output logic                            out_window_full
);

  localparam int TOT_W  = epvw_pkg::TOT_W;
  localparam int GAIN_W = epvw_pkg::GAIN_W;
  localparam int PROD_W = epvw_pkg::PROD_W;
  localparam int CNT_W  = epvw_pkg::CNT_W;
  localparam int SLOT_W = epvw_pkg::SLOT_W;
  localparam int VEL_W  = epvw_pkg::VEL_W;
  localparam int POS_W  = epvw_pkg::POS_W;

  // ---------------- configuration registers ----------------
  logic [GAIN_W-1:0] pos_gain_r;
  logic [GAIN_W-1:0] tick_gain_r;
  logic [GAIN_W-1:0] window_gain_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_gain_r    <= '0;
      tick_gain_r   <= '0;
      window_gain_r <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        epvw_pkg::CFG_POS_GAIN:    pos_gain_r    <= cfg_wdata;
        epvw_pkg::CFG_TICK_GAIN:   tick_gain_r   <= cfg_wdata;
        epvw_pkg::CFG_WINDOW_GAIN: window_gain_r <= cfg_wdata;
        default: ; // unused index, write dropped
      endcase
    end
  end

  // ---------------- stage enables ----------------
  // a stage may load when it is empty or its contents move on this cycle
  logic v1_r, v2_r, out_valid_r;
  logic en1, en2, en3;
  logic accept;

  assign en3      = !out_valid_r || !out_stall;
  assign en2      = !v2_r || en3;
  assign en1      = !v1_r || en2;
  assign in_stall = !en1;
  assign accept   = in_valid && en1;

  // ---------------- stage 0: delta, running total, history ----------------
  logic [CNT_W-1:0]  last_r;
  epvw_pkg::total_t  total_r;
  logic [SLOT_W-1:0] slot_r;
  logic              filled_r;

  logic [CNT_W-1:0]  d16;
  epvw_pkg::total_t  delta32;
  epvw_pkg::total_t  total_nxt;
  logic [SLOT_W-1:0] slot_nxt;
  logic              slot_wrap;
  logic              filled_nxt;
  epvw_pkg::total_t  oldest;
  epvw_pkg::total_t  diff_win;

  // wrap-safe signed delta: 16-bit difference taken as two's complement
  assign d16       = in_counter_value - last_r;
  assign delta32   = {{(TOT_W-CNT_W){d16[CNT_W-1]}}, d16};
  assign total_nxt = total_r + delta32;

  // slot counter counts accepted beats modulo WINDOW; its wrap marks the window as full
  assign slot_wrap  = (slot_r == SLOT_W'(epvw_pkg::WINDOW - 1));
  assign slot_nxt   = slot_wrap ? '0 : slot_r + SLOT_W'(1);
  assign filled_nxt = filled_r || slot_wrap;

  // history chain: cell 0 takes the newest total, the last cell holds the
  // total from WINDOW-1 beats back, which is the oldest entry the window uses
  epvw_pkg::total_t tap [epvw_pkg::CHAIN_LEN];

  genvar gi;
  generate
    for (gi = 0; gi < epvw_pkg::CHAIN_LEN; gi++) begin : g_chain
      if (gi == 0) begin : g_head
        epvw_cell u_cell (
          .clk      (clk),
          .shift_en (accept),
          .data_in  (total_nxt),
          .data_out (tap[gi])
        );
      end else begin : g_body
        epvw_cell u_cell (
          .clk      (clk),
          .shift_en (accept),
          .data_in  (tap[gi-1]),
          .data_out (tap[gi])
        );
      end
    end
  endgenerate

  assign oldest   = tap[epvw_pkg::CHAIN_LEN-1];
  assign diff_win = total_nxt - oldest;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r   <= '0;
      total_r  <= '0;
      slot_r   <= '0;
      filled_r <= 1'b0;
    end else if (accept) begin
      last_r   <= in_counter_value;
      total_r  <= total_nxt;
      slot_r   <= slot_nxt;
      filled_r <= filled_nxt;
    end
  end

  // ---------------- stage 1 registers: operands ----------------
  epvw_pkg::total_t s1_total_r;
  epvw_pkg::total_t s1_diff_r;
  logic             s1_full_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en1) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_total_r <= total_nxt;
      // full window uses the span difference, otherwise the single-tick delta
      s1_diff_r  <= filled_nxt ? diff_win : delta32;
      s1_full_r  <= filled_nxt;
    end
  end

  // ---------------- stage 2: the two products ----------------
  logic [GAIN_W-1:0]        vel_gain;
  logic signed [PROD_W:0]   pos_prod_full;
  logic signed [PROD_W:0]   vel_prod_full;
  logic signed [PROD_W-1:0] pos_prod_r;
  logic signed [PROD_W-1:0] vel_prod_r;
  epvw_pkg::total_t         s2_total_r;
  logic                     s2_full_r;

  assign vel_gain = s1_full_r ? window_gain_r : tick_gain_r;

  // signed total/diff times unsigned gain; the exact product fits in 64 bits
  assign pos_prod_full = (PROD_W+1)'($signed(s1_total_r))
                       * (PROD_W+1)'($signed({1'b0, pos_gain_r}));
  assign vel_prod_full = (PROD_W+1)'($signed(s1_diff_r))
                       * (PROD_W+1)'($signed({1'b0, vel_gain}));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en2) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en2 && v1_r) begin
      pos_prod_r <= pos_prod_full[PROD_W-1:0];
      vel_prod_r <= vel_prod_full[PROD_W-1:0];
      s2_total_r <= s1_total_r;
      s2_full_r  <= s1_full_r;
    end
  end

  // ---------------- stage 3: scaling, saturation, output register ----------------
  logic [POS_W-1:0] pos_scaled;
  logic [VEL_W-1:0] vel_sat;
  logic             vel_in_range;

  // floor shifts are plain part-selects of the two's complement product
  assign pos_scaled   = pos_prod_r[POS_W+15:16];
  // product >> 8 fits 32 signed bits when bits 63..39 all match the sign
  assign vel_in_range = (vel_prod_r[PROD_W-1:VEL_W+7] == '0)
                     || (vel_prod_r[PROD_W-1:VEL_W+7] == '1);
  assign vel_sat      = vel_in_range ? vel_prod_r[VEL_W+7:8]
                      : (vel_prod_r[PROD_W-1] ? {1'b1, {(VEL_W-1){1'b0}}}
                                               : {1'b0, {(VEL_W-1){1'b1}}});

  epvw_pkg::total_t  out_total_r;
  logic [POS_W-1:0]  out_pos_r;
  logic [VEL_W-1:0]  out_vel_r;
  logic              out_full_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en3) begin
      out_valid_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en3 && v2_r) begin
      out_total_r <= s2_total_r;
      out_pos_r   <= pos_scaled;
      out_vel_r   <= vel_sat;
      out_full_r  <= s2_full_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_count_total = $signed(out_total_r);
  assign out_position    = $signed(out_pos_r);
  assign out_velocity    = $signed(out_vel_r);
  assign out_window_full = out_full_r;

  // ---------------- assertions ----------------
  `EPVW_ASSERT_NEXT(a_filled_sticky, filled_r, filled_r, "window fill flag dropped")
  `EPVW_ASSERT_NEXT(a_no_early_fill, accept && !filled_r && !slot_wrap, !filled_r, "window filled before slot wrap")
  `EPVW_ASSERT_NOW(a_full_needs_fill, v1_r && s1_full_r, filled_r, "full-window beat without fill flag")
  `EPVW_ASSERT_NEXT(a_s2_holds, v2_r && !en3, v2_r && $stable(vel_prod_r), "stage 2 lost a held beat")
  `EPVW_ASSERT_NOW(a_stall_only_full, in_stall, v1_r && v2_r && out_valid_r && out_stall, "input stalled with room in the pipe")

endmodule
